// File: sv/ght_pkg.sv
package ght_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int DATA_WIDTH_DEF  = 32;

	localparam int REQ_W   = 2;
	localparam int STAT_W  = 2;
	localparam int UUID_W  = 32;
	localparam int GEN_W   = 32;
	localparam int HIDX_W  = 6;
	localparam int COUNT_W = 7;
	localparam int CFG_W   = 7;

	localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;
	localparam logic [GEN_W-1:0] GEN_RST         = 32'd1;
	localparam logic [GEN_W-1:0] GEN_MAX         = 32'hFFFF_FFFF;

	typedef enum logic [REQ_W-1:0] {
		REQ_CREATE  = 2'd0,
		REQ_GET     = 2'd1,
		REQ_DESTROY = 2'd2
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_MISSING   = 2'd1,
		ST_DESTROYED = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RES_FULL,
		RES_IGNORED,
		RES_DESTROYED,
		RES_MISSING,
		RES_CREATED,
		RES_GOT,
		RES_REMOVED
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     create;
		logic     res_we;
		res_sel_t res_sel;
		logic     scan_init;
		logic     rd_idx;
		logic     scan_rd;
		logic     pos_rd;
		logic     shift_init;
		logic     shift;
		logic     retire;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             full;
		logic             gen_zero;
		logic             gen_cur;
		logic             idx_live;
		logic             live_zero;
		logic             scan_more;
		logic             rd_vld;
		logic             match;
		logic             rd_last;
	} sts_t;

endpackage

// File: sv/ght_ctrl.sv
module ght_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ght_pkg::sts_t sts,
	output ght_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SEARCH,
		S_FOUND,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				case (sts.req)
					ght_pkg::REQ_CREATE: begin
						cmd.res_we = 1'b1;
						if (sts.full) begin
							cmd.res_sel = ght_pkg::RES_FULL;
						end else begin
							cmd.create  = 1'b1;
							cmd.res_sel = ght_pkg::RES_CREATED;
						end
					end
					ght_pkg::REQ_GET, ght_pkg::REQ_DESTROY: begin
						if (sts.gen_zero) begin
							cmd.res_we  = 1'b1;
							cmd.res_sel = ght_pkg::RES_DESTROYED;
						end else if (sts.gen_cur) begin
							if (sts.idx_live) begin
								cmd.rd_idx = 1'b1;
								state_d    = S_FOUND;
							end else begin
								cmd.res_we  = 1'b1;
								cmd.res_sel = ght_pkg::RES_MISSING;
							end
						end else if (sts.live_zero) begin
							cmd.res_we  = 1'b1;
							cmd.res_sel = ght_pkg::RES_MISSING;
						end else begin
							cmd.scan_init = 1'b1;
							state_d       = S_SEARCH;
						end
					end
					default: begin
						cmd.res_we  = 1'b1;
						cmd.res_sel = ght_pkg::RES_IGNORED;
					end
				endcase
			end
			S_SEARCH: begin
				if (sts.match) begin
					cmd.pos_rd = 1'b1;
					state_d    = S_FOUND;
				end else if (sts.rd_vld && sts.rd_last) begin
					cmd.res_we  = 1'b1;
					cmd.res_sel = ght_pkg::RES_MISSING;
					state_d     = S_DONE;
				end else if (sts.scan_more) begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_FOUND: begin
				if (sts.req == ght_pkg::REQ_GET) begin
					cmd.res_we  = 1'b1;
					cmd.res_sel = ght_pkg::RES_GOT;
					state_d     = S_DONE;
				end else begin
					cmd.shift_init = 1'b1;
					state_d        = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.scan_more) begin
					cmd.scan_rd = 1'b1;
				end else if (!sts.rd_vld) begin
					cmd.retire  = 1'b1;
					cmd.res_we  = 1'b1;
					cmd.res_sel = ght_pkg::RES_REMOVED;
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/ght_dp.sv
module ght_dp #(
	parameter int TABLE_DEPTH = ght_pkg::TABLE_DEPTH_DEF,
	parameter int DATA_WIDTH  = ght_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ght_pkg::cmd_t                 cmd,
	output ght_pkg::sts_t                 sts,
	input  logic                          cfg_wr_en,
	input  logic [ght_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic [ght_pkg::REQ_W-1:0]     req_type,
	input  logic [ght_pkg::UUID_W-1:0]    handle_uuid,
	input  logic [ght_pkg::HIDX_W-1:0]    handle_index,
	input  logic [ght_pkg::GEN_W-1:0]     handle_generation,
	input  logic [DATA_WIDTH-1:0]         new_data,
	output logic [ght_pkg::STAT_W-1:0]    status,
	output logic [ght_pkg::UUID_W-1:0]    out_uuid,
	output logic [ght_pkg::HIDX_W-1:0]    out_index,
	output logic [ght_pkg::GEN_W-1:0]     out_generation,
	output logic [DATA_WIDTH-1:0]         out_data,
	output logic [ght_pkg::COUNT_W-1:0]   entry_count
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = ((CNT_W > ght_pkg::COUNT_W) ? CNT_W : ght_pkg::COUNT_W) + 1;
	localparam int ENT_W = ght_pkg::UUID_W + DATA_WIDTH;

	// slot store: {uuid, data}
	logic [ENT_W-1:0] mem_q [TABLE_DEPTH];

	logic [ght_pkg::CFG_W-1:0]  max_entries_q;
	logic [CNT_W-1:0]           live_q;
	logic [ght_pkg::GEN_W-1:0]  gen_q;
	logic [ght_pkg::UUID_W-1:0] uuid_ctr_q;

	logic [ght_pkg::REQ_W-1:0]  req_q;
	logic [ght_pkg::UUID_W-1:0] huuid_q;
	logic [ght_pkg::HIDX_W-1:0] hidx_q;
	logic [ght_pkg::GEN_W-1:0]  hgen_q;
	logic [DATA_WIDTH-1:0]      ndata_q;

	logic [CNT_W-1:0]           scan_q;
	logic [IDX_W-1:0]           pos_q;
	logic [ENT_W-1:0]           rd_s1;
	logic [IDX_W-1:0]           rd_addr_s1;
	logic                       rd_vld_s1;

	logic [ght_pkg::STAT_W-1:0] res_status_q;
	logic [ght_pkg::UUID_W-1:0] res_uuid_q;
	logic [ght_pkg::HIDX_W-1:0] res_index_q;
	logic [ght_pkg::GEN_W-1:0]  res_gen_q;
	logic [DATA_WIDTH-1:0]      res_data_q;

	logic [ght_pkg::STAT_W-1:0] res_status_d;
	logic [ght_pkg::UUID_W-1:0] res_uuid_d;
	logic [ght_pkg::HIDX_W-1:0] res_index_d;
	logic [ght_pkg::GEN_W-1:0]  res_gen_d;
	logic [DATA_WIDTH-1:0]      res_data_d;

	logic [ght_pkg::STAT_W-1:0] out_status_q;
	logic [ght_pkg::UUID_W-1:0] out_uuid_q;
	logic [ght_pkg::HIDX_W-1:0] out_index_q;
	logic [ght_pkg::GEN_W-1:0]  out_gen_q;
	logic [DATA_WIDTH-1:0]      out_data_q;
	logic [ght_pkg::COUNT_W-1:0] out_count_q;

	logic [CMP_W-1:0]           limit;
	logic [ght_pkg::UUID_W-1:0] uuid_next;
	logic [ght_pkg::GEN_W-1:0]  gen_next;
	logic                       rd_en;
	logic [IDX_W-1:0]           rd_addr;
	logic                       wr_en;
	logic [IDX_W-1:0]           wr_addr;
	logic [ENT_W-1:0]           wr_data;

	assign limit = (CMP_W'(max_entries_q) < CMP_W'(TABLE_DEPTH)) ? CMP_W'(max_entries_q)
	                                                             : CMP_W'(TABLE_DEPTH);
	assign uuid_next = uuid_ctr_q + 1'b1;
	assign gen_next  = (gen_q == ght_pkg::GEN_MAX) ? ght_pkg::GEN_RST : gen_q + 1'b1;

	assign sts.req       = req_q;
	assign sts.full      = (CMP_W'(live_q) + CMP_W'(1)) > limit;
	assign sts.gen_zero  = (hgen_q == '0);
	assign sts.gen_cur   = (hgen_q == gen_q);
	assign sts.idx_live  = CMP_W'(hidx_q) < CMP_W'(live_q);
	assign sts.live_zero = (live_q == '0);
	assign sts.scan_more = (scan_q < live_q);
	assign sts.rd_vld    = rd_vld_s1;
	assign sts.match     = rd_vld_s1 && (rd_s1[ENT_W-1 -: ght_pkg::UUID_W] == huuid_q);
	assign sts.rd_last   = (CMP_W'(rd_addr_s1) + CMP_W'(1)) == CMP_W'(live_q);

	assign rd_en   = cmd.rd_idx || cmd.scan_rd;
	assign rd_addr = cmd.rd_idx ? IDX_W'(hidx_q) : IDX_W'(scan_q);
	assign wr_en   = cmd.create || (cmd.shift && rd_vld_s1);
	assign wr_addr = cmd.create ? IDX_W'(live_q) : rd_addr_s1 - 1'b1;
	assign wr_data = cmd.create ? {uuid_next, ndata_q} : rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1      <= mem_q[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= ght_pkg::MAX_ENTRIES_RST;
			live_q        <= '0;
			gen_q         <= ght_pkg::GEN_RST;
			uuid_ctr_q    <= '0;
			rd_vld_s1     <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (cfg_wr_en) begin
				max_entries_q <= cfg_wr_data;
			end
			if (cmd.create) begin
				uuid_ctr_q <= uuid_next;
				live_q     <= live_q + 1'b1;
			end else if (cmd.retire) begin
				live_q <= live_q - 1'b1;
				gen_q  <= gen_next;
			end
		end
	end

	always_comb begin
		res_status_d = ght_pkg::ST_OK;
		res_uuid_d   = huuid_q;
		res_index_d  = hidx_q;
		res_gen_d    = hgen_q;
		res_data_d   = '0;
		case (cmd.res_sel)
			ght_pkg::RES_FULL: begin
				res_status_d = ght_pkg::ST_FULL;
				res_uuid_d   = '0;
				res_index_d  = '0;
				res_gen_d    = '0;
			end
			ght_pkg::RES_DESTROYED: begin
				res_status_d = ght_pkg::ST_DESTROYED;
			end
			ght_pkg::RES_MISSING: begin
				res_status_d = ght_pkg::ST_MISSING;
				if (req_q == ght_pkg::REQ_DESTROY) begin
					res_gen_d = '0;
				end
			end
			ght_pkg::RES_CREATED: begin
				res_uuid_d  = uuid_next;
				res_index_d = ght_pkg::HIDX_W'(live_q);
				res_gen_d   = gen_q;
				res_data_d  = ndata_q;
			end
			ght_pkg::RES_GOT: begin
				res_index_d = ght_pkg::HIDX_W'(pos_q);
				res_gen_d   = gen_q;
				res_data_d  = rd_s1[DATA_WIDTH-1:0];
			end
			ght_pkg::RES_REMOVED: begin
				res_index_d = ght_pkg::HIDX_W'(pos_q);
				res_gen_d   = gen_q;
			end
			default: begin
				res_status_d = ght_pkg::ST_MISSING;
				res_uuid_d   = '0;
				res_index_d  = '0;
				res_gen_d    = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			huuid_q <= handle_uuid;
			hidx_q  <= handle_index;
			hgen_q  <= handle_generation;
			ndata_q <= new_data;
		end
		if (cmd.scan_init) begin
			scan_q <= '0;
		end else if (cmd.shift_init) begin
			scan_q <= CNT_W'(pos_q) + 1'b1;
		end else if (cmd.scan_rd) begin
			scan_q <= scan_q + 1'b1;
		end
		if (cmd.rd_idx) begin
			pos_q <= IDX_W'(hidx_q);
		end else if (cmd.pos_rd) begin
			pos_q <= rd_addr_s1;
		end
		if (cmd.res_we) begin
			res_status_q <= res_status_d;
			res_uuid_q   <= res_uuid_d;
			res_index_q  <= res_index_d;
			res_gen_q    <= res_gen_d;
			res_data_q   <= res_data_d;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_uuid_q   <= res_uuid_q;
			out_index_q  <= res_index_q;
			out_gen_q    <= res_gen_q;
			out_data_q   <= res_data_q;
			out_count_q  <= ght_pkg::COUNT_W'(live_q);
		end
	end

	assign status         = out_status_q;
	assign out_uuid       = out_uuid_q;
	assign out_index      = out_index_q;
	assign out_generation = out_gen_q;
	assign out_data       = out_data_q;
	assign entry_count    = out_count_q;

endmodule

// File: sv/generational_handle_table_core.sv
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------------
// request   | in_valid / in_ready   | req_type handle_uuid handle_index
//           |                       | handle_generation new_data
// result    | out_valid / out_ready | status out_uuid out_index out_generation
//           |                       | out_data entry_count
// config    | cfg_wr_en             | cfg_wr_data (max_entries)
//
// One request at a time. Create, unknown type, destroyed handle and a miss at the current
// generation are answered from the captured request; a get or destroy at the current
// generation first reads the indexed slot. A stale handle walks the slots one a cycle until a
// match or the last live slot (no walk on an empty table); destroy then shifts later slots down
// one a cycle. Reset clears counters and resets generation and max_entries, not the slots.
// A result waiting on out_ready holds the next one in the core; in_ready rises with out_valid.
module generational_handle_table_core #(
	parameter int TABLE_DEPTH = ght_pkg::TABLE_DEPTH_DEF,
	parameter int DATA_WIDTH  = ght_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ght_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ght_pkg::REQ_W-1:0]     req_type,
	input  logic [ght_pkg::UUID_W-1:0]    handle_uuid,
	input  logic [ght_pkg::HIDX_W-1:0]    handle_index,
	input  logic [ght_pkg::GEN_W-1:0]     handle_generation,
	input  logic [DATA_WIDTH-1:0]         new_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ght_pkg::STAT_W-1:0]    status,
	output logic [ght_pkg::UUID_W-1:0]    out_uuid,
	output logic [ght_pkg::HIDX_W-1:0]    out_index,
	output logic [ght_pkg::GEN_W-1:0]     out_generation,
	output logic [DATA_WIDTH-1:0]         out_data,
	output logic [ght_pkg::COUNT_W-1:0]   entry_count
);

	ght_pkg::cmd_t cmd;
	ght_pkg::sts_t sts;

	ght_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ght_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.req_type          (req_type),
		.handle_uuid       (handle_uuid),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.new_data          (new_data),
		.status            (status),
		.out_uuid          (out_uuid),
		.out_index         (out_index),
		.out_generation    (out_generation),
		.out_data          (out_data),
		.entry_count       (entry_count)
	);

endmodule

// File: sv/ght_checker.sv
module ght_checker #(
	parameter int DATA_WIDTH = ght_pkg::DATA_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ght_pkg::STAT_W-1:0]    status,
	input logic [ght_pkg::UUID_W-1:0]    out_uuid,
	input logic [ght_pkg::HIDX_W-1:0]    out_index,
	input logic [ght_pkg::GEN_W-1:0]     out_generation,
	input logic [DATA_WIDTH-1:0]         out_data,
	input logic [ght_pkg::COUNT_W-1:0]   entry_count
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_uuid)
			&& $stable(out_index) && $stable(out_generation) && $stable(out_data)
			&& $stable(entry_count))
		else $error("result changed while stalled");

	// one request in flight
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_ok_gen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ght_pkg::ST_OK |-> out_generation != '0)
		else $error("ok result with zero generation");

	a_destroyed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ght_pkg::ST_DESTROYED |-> out_generation == '0
			&& out_data == '0)
		else $error("destroyed handle not echoed");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ght_pkg::ST_FULL |-> out_uuid == '0 && out_index == '0
			&& out_generation == '0 && out_data == '0)
		else $error("full result carries a handle");

endmodule

bind generational_handle_table_core ght_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ght_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.out_uuid       (out_uuid),
	.out_index      (out_index),
	.out_generation (out_generation),
	.out_data       (out_data),
	.entry_count    (entry_count)
);

// File: dv/ght_checker.sv
`timescale 1ns / 100ps

module ght_tb_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ght_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [ght_pkg::REQ_W-1:0]     req_type,
	input  logic [ght_pkg::UUID_W-1:0]    handle_uuid,
	input  logic [ght_pkg::HIDX_W-1:0]    handle_index,
	input  logic [ght_pkg::GEN_W-1:0]     handle_generation,
	input  logic [31:0]                   new_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [ght_pkg::STAT_W-1:0]    status,
	input  logic [ght_pkg::UUID_W-1:0]    out_uuid,
	input  logic [ght_pkg::HIDX_W-1:0]    out_index,
	input  logic [ght_pkg::GEN_W-1:0]     out_generation,
	input  logic [31:0]                   out_data,
	input  logic [ght_pkg::COUNT_W-1:0]   entry_count,
	output int                            mismatches,
	output int                            awaited
);

	localparam int TABLE_DEPTH = ght_pkg::TABLE_DEPTH_DEF;

	typedef struct packed {
		logic [ght_pkg::REQ_W-1:0]  kind;
		logic [ght_pkg::UUID_W-1:0] uuid;
		logic [ght_pkg::HIDX_W-1:0] index;
		logic [ght_pkg::GEN_W-1:0]  gen;
		logic [31:0]                data;
	} request_t;

	typedef struct packed {
		ght_pkg::status_t            status;
		logic [ght_pkg::UUID_W-1:0]  uuid;
		logic [ght_pkg::HIDX_W-1:0]  index;
		logic [ght_pkg::GEN_W-1:0]   gen;
		logic [31:0]                 data;
		logic [ght_pkg::COUNT_W-1:0] count;
	} result_t;

	logic [ght_pkg::UUID_W-1:0]  slot_uuid [TABLE_DEPTH];
	logic [31:0]                 slot_data [TABLE_DEPTH];
	logic [ght_pkg::COUNT_W-1:0] live_count;
	logic [ght_pkg::GEN_W-1:0]   table_gen;
	logic [ght_pkg::UUID_W-1:0]  uuid_ctr;
	logic [ght_pkg::CFG_W-1:0]   limit_reg;
	result_t                     pending_results [$];
	int                          fail_count = 0;

	assign mismatches = fail_count;
	assign awaited    = pending_results.size();

	function automatic result_t resolve_request(request_t rq);
		result_t                     r;
		logic [ght_pkg::COUNT_W-1:0] cap;
		logic                        found;
		int                          pos;
		r = '0;
		r.status = ght_pkg::ST_MISSING;
		cap = (limit_reg < TABLE_DEPTH) ? limit_reg : ght_pkg::COUNT_W'(TABLE_DEPTH);
		found = 1'b0;
		pos = 0;
		case (rq.kind)
			ght_pkg::REQ_CREATE: begin
				if (live_count >= cap) begin
					r.status = ght_pkg::ST_FULL;
				end else begin
					uuid_ctr = uuid_ctr + 1'b1;
					slot_uuid[live_count[ght_pkg::HIDX_W-1:0]] = uuid_ctr;
					slot_data[live_count[ght_pkg::HIDX_W-1:0]] = rq.data;
					r.status = ght_pkg::ST_OK;
					r.uuid   = uuid_ctr;
					r.index  = live_count[ght_pkg::HIDX_W-1:0];
					r.gen    = table_gen;
					r.data   = rq.data;
					live_count = live_count + 1'b1;
				end
			end
			ght_pkg::REQ_GET, ght_pkg::REQ_DESTROY: begin
				r.uuid  = rq.uuid;
				r.index = rq.index;
				r.gen   = rq.gen;
				if (rq.gen == '0) begin
					r.status = ght_pkg::ST_DESTROYED;
				end else begin
					if (rq.gen != table_gen) begin
						for (int i = 0; i < live_count; i++)
							if (!found && slot_uuid[i] == rq.uuid) begin
								found = 1'b1;
								pos = i;
							end
					end else if (rq.index < live_count) begin
						found = 1'b1;
						pos = int'(rq.index);
					end
					if (!found) begin
						if (rq.kind == ght_pkg::REQ_DESTROY)
							r.gen = '0;
					end else begin
						r.status = ght_pkg::ST_OK;
						r.index  = pos[ght_pkg::HIDX_W-1:0];
						r.gen    = table_gen;
						if (rq.kind == ght_pkg::REQ_GET) begin
							r.data = slot_data[pos];
						end else begin
							for (int i = pos; i + 1 < live_count; i++) begin
								slot_uuid[i] = slot_uuid[i+1];
								slot_data[i] = slot_data[i+1];
							end
							live_count = live_count - 1'b1;
							table_gen = (table_gen == ght_pkg::GEN_MAX) ? ght_pkg::GEN_RST
								: table_gen + 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		r.count = live_count;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t  exp;
		request_t rq;
		if (!arst_n) begin
			live_count = '0;
			table_gen  = ght_pkg::GEN_RST;
			uuid_ctr   = '0;
			limit_reg  = ght_pkg::MAX_ENTRIES_RST;
			pending_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					exp = pending_results.pop_front();
					compare_field("status", 32'(exp.status), 32'(status));
					compare_field("out_uuid", exp.uuid, out_uuid);
					compare_field("out_index", 32'(exp.index), 32'(out_index));
					compare_field("out_generation", exp.gen, out_generation);
					compare_field("out_data", exp.data, out_data);
					compare_field("entry_count", 32'(exp.count), 32'(entry_count));
				end
			end
			if (cfg_wr_en)
				limit_reg = cfg_wr_data;
			if (in_valid && in_ready) begin
				rq = '{req_type, handle_uuid, handle_index, handle_generation, new_data};
				pending_results.push_back(resolve_request(rq));
			end
		end
	end

endmodule

// File: dv/generational_handle_table_core_tb.sv
`timescale 1ns / 100ps

module generational_handle_table_core_tb;

	localparam logic [ght_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 210;

	typedef struct {
		logic [ght_pkg::UUID_W-1:0] uuid;
		logic [ght_pkg::HIDX_W-1:0] index;
		logic [ght_pkg::GEN_W-1:0]  gen;
	} handle_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [ght_pkg::CFG_W-1:0]     cfg_wr_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [ght_pkg::REQ_W-1:0]     req_type = '0;
	logic [ght_pkg::UUID_W-1:0]    handle_uuid = '0;
	logic [ght_pkg::HIDX_W-1:0]    handle_index = '0;
	logic [ght_pkg::GEN_W-1:0]     handle_generation = '0;
	logic [31:0]                   new_data = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [ght_pkg::STAT_W-1:0]    status;
	logic [ght_pkg::UUID_W-1:0]    out_uuid;
	logic [ght_pkg::HIDX_W-1:0]    out_index;
	logic [ght_pkg::GEN_W-1:0]     out_generation;
	logic [31:0]                   out_data;
	logic [ght_pkg::COUNT_W-1:0]   entry_count;

	int                            fails;
	int                            outstanding;
	logic                          steady = 1'b0;
	int                            stall_cycles = 0;
	handle_t                       live_handles [$];
	handle_t                       dead_handles [$];
	logic [ght_pkg::REQ_W-1:0]     sent_kinds [$];
	logic [ght_pkg::GEN_W-1:0]     last_gen = ght_pkg::GEN_RST;

	generational_handle_table_core dut (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data,
		.in_valid, .in_ready, .req_type, .handle_uuid, .handle_index,
		.handle_generation, .new_data,
		.out_valid, .out_ready, .status, .out_uuid, .out_index,
		.out_generation, .out_data, .entry_count
	);

	ght_tb_checker chk (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data,
		.in_valid, .in_ready, .req_type, .handle_uuid, .handle_index,
		.handle_generation, .new_data,
		.out_valid, .out_ready, .status, .out_uuid, .out_index,
		.out_generation, .out_data, .entry_count,
		.mismatches(fails), .awaited(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(99) >= 23);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("FAIL generational_handle_table_core");
		$finish;
	end

	// track returned handles so later requests can reuse them
	always @(posedge clk) begin
		logic [ght_pkg::REQ_W-1:0] kind;
		if (in_valid && in_ready)
			sent_kinds.push_back(req_type);
		if (out_valid && out_ready && sent_kinds.size() > 0) begin
			kind = sent_kinds.pop_front();
			if (status == ght_pkg::ST_OK) begin
				case (kind)
					ght_pkg::REQ_CREATE: begin
						live_handles.push_back('{out_uuid, out_index, out_generation});
						last_gen = out_generation;
					end
					ght_pkg::REQ_GET: begin
						foreach (live_handles[i])
							if (live_handles[i].uuid == out_uuid) begin
								live_handles[i].index = out_index;
								live_handles[i].gen   = out_generation;
							end
						last_gen = out_generation;
					end
					ght_pkg::REQ_DESTROY: begin
						for (int i = live_handles.size() - 1; i >= 0; i--)
							if (live_handles[i].uuid == out_uuid)
								live_handles.delete(i);
						dead_handles.push_back('{out_uuid, out_index, out_generation});
						if (dead_handles.size() > 16)
							void'(dead_handles.pop_front());
						last_gen = (out_generation == ght_pkg::GEN_MAX) ? ght_pkg::GEN_RST
							: out_generation + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	task automatic issue(logic [ght_pkg::REQ_W-1:0] kind, logic [ght_pkg::UUID_W-1:0] uuid,
			logic [ght_pkg::HIDX_W-1:0] idx, logic [ght_pkg::GEN_W-1:0] gen,
			logic [31:0] data);
		while (!steady && $urandom_range(99) < 23) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		req_type          = kind;
		handle_uuid       = uuid;
		handle_index      = idx;
		handle_generation = gen;
		new_data          = data;
		in_valid          = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(logic [ght_pkg::CFG_W-1:0] value);
		cfg_wr_data = value;
		cfg_wr_en   = 1'b1;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	task automatic send_random(int create_pct);
		int                         roll;
		handle_t                    h;
		logic [ght_pkg::REQ_W-1:0]  kind;
		logic [ght_pkg::UUID_W-1:0] uuid;
		logic [ght_pkg::HIDX_W-1:0] idx;
		logic [ght_pkg::GEN_W-1:0]  gen;
		roll = $urandom_range(99);
		uuid = $urandom();
		idx  = ght_pkg::HIDX_W'($urandom_range(63));
		gen  = $urandom();
		if (roll < create_pct) begin
			kind = ght_pkg::REQ_CREATE;
		end else if (roll < 82 && live_handles.size() > 0) begin
			h = live_handles[$urandom_range(live_handles.size() - 1)];
			kind = ($urandom_range(4) < 2) ? ght_pkg::REQ_DESTROY : ght_pkg::REQ_GET;
			uuid = h.uuid;
			idx  = h.index;
			gen  = ($urandom_range(5) == 0) ? last_gen : h.gen;
		end else begin
			kind = $urandom_range(1) ? ght_pkg::REQ_GET : ght_pkg::REQ_DESTROY;
			case ($urandom_range(5))
				0: gen = '0;
				1: if (dead_handles.size() > 0) begin
					h = dead_handles[$urandom_range(dead_handles.size() - 1)];
					uuid = h.uuid;
					idx  = h.index;
					gen  = h.gen;
				end
				2: gen = last_gen;
				3: kind = REQ_UNKNOWN;
				default: ;
			endcase
		end
		issue(kind, uuid, idx, gen, $urandom());
	endtask

	initial begin
		int cfg_plan [PHASES];
		int create_plan [PHASES];
		cfg_plan    = '{0, 1, 3, 127, 64, 0, 2, 64};
		create_plan = '{30, 30, 30, 45, 55, 25, 30, 25};
		cfg_plan[5] = int'($urandom_range(4, 63));

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		write_limit(ght_pkg::MAX_ENTRIES_RST);

		// empty table: destroyed, out-of-range and unknown requests, then creates, gets and destroys
		issue(ght_pkg::REQ_GET, 32'd1, 6'd0, '0, '0);
		issue(ght_pkg::REQ_DESTROY, 32'hFFFF_FFFF, 6'd63, '0, '1);
		issue(ght_pkg::REQ_GET, 32'd1, 6'd0, ght_pkg::GEN_RST, '0);
		issue(ght_pkg::REQ_DESTROY, 32'd1, 6'd0, ght_pkg::GEN_RST, '0);
		issue(REQ_UNKNOWN, '1, '1, '1, '1);
		issue(ght_pkg::REQ_CREATE, '0, '0, '0, 32'hFFFF_FFFF);
		issue(ght_pkg::REQ_CREATE, '1, '1, '1, 32'h0000_0000);
		issue(ght_pkg::REQ_CREATE, '0, '0, '0, 32'hA5A5_A5A5);
		issue(ght_pkg::REQ_GET, 32'd1, 6'd0, ght_pkg::GEN_RST, '0);
		issue(ght_pkg::REQ_GET, 32'd3, 6'd63, ght_pkg::GEN_RST, '0);
		issue(ght_pkg::REQ_GET, 32'd3, 6'd0, ght_pkg::GEN_MAX, '0);
		issue(ght_pkg::REQ_DESTROY, 32'd2, 6'd1, ght_pkg::GEN_RST, '0);
		issue(ght_pkg::REQ_GET, 32'd3, 6'd2, ght_pkg::GEN_RST, '0);
		issue(ght_pkg::REQ_GET, 32'd2, 6'd1, 32'd2, '0);
		issue(ght_pkg::REQ_DESTROY, 32'd2, 6'd1, ght_pkg::GEN_MAX, '0);
		issue(ght_pkg::REQ_DESTROY, 32'd1, 6'd0, 32'd2, '0);
		issue(ght_pkg::REQ_DESTROY, 32'd3, 6'd5, ght_pkg::GEN_RST, '0);
		issue(ght_pkg::REQ_GET, 32'd3, 6'd0, 32'd4, '0);
		issue(ght_pkg::REQ_CREATE, '0, '0, '0, 32'h5A5A_5A5A);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_limit(ght_pkg::CFG_W'(cfg_plan[p]));
			steady = (p == 4);
			repeat (PHASE_ITEMS) send_random(create_plan[p]);
		end
		drain();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("PASS generational_handle_table_core");
		else
			$display("FAIL generational_handle_table_core");
		$finish;
	end

endmodule

// File: filelist.f
sv/ght_pkg.sv
sv/ght_ctrl.sv
sv/ght_dp.sv
sv/generational_handle_table_core.sv
sv/ght_checker.sv
dv/ght_checker.sv
dv/generational_handle_table_core_tb.sv
